// ===== rtl/ofw_pkg.sv =====
// Package for the overlapped framing / analysis window block.
// Holds payload structs, controller-datapath command and status structs,
// register indexes and shared helper functions. No dependencies.
`default_nettype none

package ofw_pkg;

    // Defaults for the top-level parameters
    localparam int BLOCK_MAX_DEF   = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed field widths
    localparam int VALUE_W   = 16;
    localparam int CIDX_W    = 6;
    localparam int FRAME_W   = 16;
    localparam int POS_W     = 6;
    localparam int PROD_W    = 32;
    localparam int BLK_W     = 7;
    localparam int CNT_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Largest frame the 6-bit position field can address
    localparam int POS_LIM = 64;

    // Result queue depth; the credit check in the datapath relies on it
    localparam int OUT_DEPTH = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOP_SIZE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 2'd2;

    // Register reset values
    localparam logic [BLK_W-1:0]   BLOCK_SIZE_RST  = 7'd64;
    localparam logic [BLK_W-1:0]   HOP_SIZE_RST    = 7'd32;
    localparam logic [FRAME_W-1:0] FRAME_COUNT_RST = 16'd0;

    // Item modes
    localparam logic MODE_COEFF  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef struct packed {
        logic                      mode;
        logic [CIDX_W-1:0]         coeff_index;
        logic signed [VALUE_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic [FRAME_W-1:0]       frame_index;
        logic [POS_W-1:0]         position;
        logic signed [PROD_W-1:0] product;
        logic                     last;
    } out_t;

    // Controller to datapath
    typedef struct packed {
        logic               win_wr;       // store a window coefficient
        logic               ring_wr;      // store a sample
        logic               frame_start;  // this sample closes a frame
        logic               issue;        // launch one frame element
        logic               last;         // element is the final one of its frame
        logic [BLK_W-1:0]   blk;          // effective block size
        logic [POS_W-1:0]   pos;          // element position
        logic [FRAME_W-1:0] frame_index;
    } ofw_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic space;  // room for one more element in flight
    } ofw_stat_t;

    // Clamp the block size register into 1..lim
    function automatic logic [BLK_W-1:0] eff_block(input logic [BLK_W-1:0] raw,
                                                  input logic [BLK_W-1:0] lim);
        logic [BLK_W-1:0] b;
        b = raw;
        if (b == '0)
        begin
            b = 7'd1;
        end
        if (b > lim)
        begin
            b = lim;
        end
        return b;
    endfunction

    // Hop of zero acts as one
    function automatic logic [BLK_W-1:0] eff_hop(input logic [BLK_W-1:0] raw);
        return (raw == '0) ? 7'd1 : raw;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/overlap_frame_windowing.sv =====
// Overlapped framing with analysis window. A coefficient load or a sample that
// does not close a frame is accepted without a stall. A sample that closes a
// frame holds the input while its block_size elements go into the read/multiply
// pipeline, one element per cycle while the result queue has credit; each passes
// the read registers and the product register into the result queue. A
// block_size or hop_size write holds the input while the frame end is realigned.
// Reset (rst_n, async, active low) clears counters and control registers; memories and data regs are not cleared.
`default_nettype none

module overlap_frame_windowing #(
    parameter int BLOCK_MAX   = ofw_pkg::BLOCK_MAX_DEF,
    parameter int SAMPLE_BITS = ofw_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            item_valid,
    output logic                                 item_stall,
    input  wire ofw_pkg::in_t                    item,
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output ofw_pkg::out_t                        result,
    input  wire logic                            cfg_wr_en,
    input  wire logic [ofw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ofw_pkg::CFG_DATA_W-1:0]  cfg_data
);

    ofw_pkg::ofw_cmd_t  cmd;
    ofw_pkg::ofw_stat_t stat;

    ofw_ctrl #(
        .BLOCK_MAX (BLOCK_MAX)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .stat       (stat),
        .cmd        (cmd)
    );

    ofw_datapath #(
        .BLOCK_MAX   (BLOCK_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== rtl/ofw_ctrl.sv =====
// Controller for the overlapped framing block: configuration registers,
// sample/frame counters, frame realignment and the emission state machine.
// Depends on ofw_pkg.
`default_nettype none

module ofw_ctrl #(
    parameter int BLOCK_MAX = ofw_pkg::BLOCK_MAX_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            item_valid,
    output logic                                 item_stall,
    input  wire ofw_pkg::in_t                    item,
    input  wire logic                            cfg_wr_en,
    input  wire logic [ofw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ofw_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire ofw_pkg::ofw_stat_t              stat,
    output ofw_pkg::ofw_cmd_t                    cmd
);

    localparam int BLK_LIM_I = (BLOCK_MAX < ofw_pkg::POS_LIM) ? BLOCK_MAX : ofw_pkg::POS_LIM;
    localparam logic [ofw_pkg::BLK_W-1:0] BLK_LIM = ofw_pkg::BLK_W'(BLK_LIM_I);
    localparam int PRODF_W = ofw_pkg::FRAME_W + ofw_pkg::BLK_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t                          state_reg, state_next;
    logic [ofw_pkg::BLK_W-1:0]       block_reg;
    logic [ofw_pkg::BLK_W-1:0]       hop_reg;
    logic [ofw_pkg::FRAME_W-1:0]     fcount_reg;
    logic [ofw_pkg::CNT_W-1:0]       seen_reg, seen_next;
    logic [ofw_pkg::FRAME_W-1:0]     fdone_reg, fdone_next;
    logic [ofw_pkg::CNT_W-1:0]       nend_reg, nend_next;
    logic [ofw_pkg::FRAME_W-1:0]     cur_frame_reg, cur_frame_next;
    logic [ofw_pkg::POS_W-1:0]       elem_reg, elem_next;
    logic [1:0]                      pend_reg, pend_next;
    logic [PRODF_W-1:0]              prodf_reg;

    logic [ofw_pkg::BLK_W-1:0]       blk_eff;
    logic [ofw_pkg::BLK_W-1:0]       hop_eff;
    logic                            acc;
    logic                            frames_left;
    logic [ofw_pkg::CNT_W-1:0]       seen_inc;
    logic                            hit;
    logic                            elem_last;
    logic [ofw_pkg::CNT_W-1:0]       realign_end;
    logic [ofw_pkg::CNT_W-1:0]       realign_diff;
    logic                            cfg_geom;

    assign blk_eff    = ofw_pkg::eff_block(block_reg, BLK_LIM);
    assign hop_eff    = ofw_pkg::eff_hop(hop_reg);
    assign item_stall = (state_reg != ST_IDLE) || (pend_reg != 2'b00);
    assign acc        = item_valid && !item_stall;
    assign frames_left = fdone_reg < fcount_reg;
    assign seen_inc   = seen_reg + ofw_pkg::CNT_W'(1);
    assign elem_last  = ({1'b0, elem_reg} == (blk_eff - ofw_pkg::BLK_W'(1)));

    assign cfg_geom = cfg_wr_en &&
                      ((cfg_index == ofw_pkg::REG_BLOCK_SIZE) ||
                       (cfg_index == ofw_pkg::REG_HOP_SIZE));

    // Pending frame end after a geometry change
    assign realign_end  = ofw_pkg::CNT_W'(prodf_reg) + ofw_pkg::CNT_W'(blk_eff);
    assign realign_diff = realign_end - seen_reg - ofw_pkg::CNT_W'(1);

    always_comb
    begin
        cmd             = '0;
        cmd.blk         = blk_eff;
        cmd.pos         = elem_reg;
        cmd.frame_index = cur_frame_reg;
        cmd.last        = elem_last;
        cmd.win_wr      = acc && (item.mode == ofw_pkg::MODE_COEFF);
        cmd.ring_wr     = acc && (item.mode == ofw_pkg::MODE_SAMPLE) && frames_left;
        hit             = cmd.ring_wr && (seen_inc == nend_reg);
        cmd.frame_start = hit;
        cmd.issue       = (state_reg == ST_EMIT) && stat.space;

        state_next     = state_reg;
        seen_next      = seen_reg;
        fdone_next     = fdone_reg;
        nend_next      = nend_reg;
        cur_frame_next = cur_frame_reg;
        elem_next      = elem_reg;
        pend_next      = {pend_reg[0], cfg_geom};

        if (pend_reg[1])
        begin
            nend_next = realign_diff[ofw_pkg::CNT_W-1] ?
                        (seen_reg + ofw_pkg::CNT_W'(blk_eff)) : realign_end;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.ring_wr)
                begin
                    seen_next = seen_inc;
                end
                if (hit)
                begin
                    cur_frame_next = fdone_reg;
                    fdone_next     = fdone_reg + ofw_pkg::FRAME_W'(1);
                    nend_next      = nend_reg + ofw_pkg::CNT_W'(hop_eff);
                    elem_next      = '0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (cmd.issue)
                begin
                    if (elem_last)
                    begin
                        elem_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        elem_next = elem_reg + ofw_pkg::POS_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            block_reg     <= ofw_pkg::BLOCK_SIZE_RST;
            hop_reg       <= ofw_pkg::HOP_SIZE_RST;
            fcount_reg    <= ofw_pkg::FRAME_COUNT_RST;
            seen_reg      <= '0;
            fdone_reg     <= '0;
            nend_reg      <= ofw_pkg::CNT_W'(ofw_pkg::eff_block(ofw_pkg::BLOCK_SIZE_RST,
                                                                 BLK_LIM));
            cur_frame_reg <= '0;
            elem_reg      <= '0;
            pend_reg      <= '0;
            prodf_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            fdone_reg     <= fdone_next;
            nend_reg      <= nend_next;
            cur_frame_reg <= cur_frame_next;
            elem_reg      <= elem_next;
            pend_reg      <= pend_next;
            // Refreshed every cycle from fdone_reg and the registered hop size
            prodf_reg     <= PRODF_W'(fdone_reg) * PRODF_W'(hop_eff);
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    ofw_pkg::REG_BLOCK_SIZE:  block_reg  <= cfg_data[ofw_pkg::BLK_W-1:0];
                    ofw_pkg::REG_HOP_SIZE:    hop_reg    <= cfg_data[ofw_pkg::BLK_W-1:0];
                    ofw_pkg::REG_FRAME_COUNT: fcount_reg <= cfg_data[ofw_pkg::FRAME_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

`ifndef ASSERT_OFF
    a_start_on_sample: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.frame_start |-> cmd.ring_wr)
        else $error("frame start without a sample write");

    a_frame_counted: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.frame_start |=> (fdone_reg == $past(fdone_reg) + ofw_pkg::FRAME_W'(1)))
        else $error("frame counter did not advance on frame start");

    a_last_ends_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue && cmd.last) |=> (state_reg == ST_IDLE))
        else $error("emission did not end after the last element");
`endif

endmodule

`default_nettype wire

// ===== rtl/ofw_datapath.sv =====
// Datapath for the overlapped framing block: sample ring and window table
// memories, multiply pipeline and result queue with credit flow control.
// Depends on ofw_pkg.
`default_nettype none

module ofw_datapath #(
    parameter int BLOCK_MAX   = ofw_pkg::BLOCK_MAX_DEF,
    parameter int SAMPLE_BITS = ofw_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ofw_pkg::in_t       item,
    input  wire ofw_pkg::ofw_cmd_t  cmd,
    output ofw_pkg::ofw_stat_t      stat,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output ofw_pkg::out_t           result
);

    localparam int AW        = $clog2(BLOCK_MAX);
    localparam int WIN_DEPTH = (BLOCK_MAX < ofw_pkg::POS_LIM) ? BLOCK_MAX : ofw_pkg::POS_LIM;
    localparam int WIN_AW    = $clog2(WIN_DEPTH);
    localparam int MUL_W     = SAMPLE_BITS + ofw_pkg::VALUE_W;
    localparam int QAW       = $clog2(ofw_pkg::OUT_DEPTH);
    localparam int QCW       = $clog2(ofw_pkg::OUT_DEPTH + 1);
    localparam int OCC_W     = QCW + 1;

    typedef struct packed {
        logic [ofw_pkg::FRAME_W-1:0] frame_index;
        logic [ofw_pkg::POS_W-1:0]   position;
        logic                        last;
    } meta_t;

    logic signed [SAMPLE_BITS-1:0]      ring_mem [BLOCK_MAX];
    logic signed [ofw_pkg::VALUE_W-1:0] win_mem  [WIN_DEPTH];
    ofw_pkg::out_t                      q_mem    [ofw_pkg::OUT_DEPTH];

    logic [AW-1:0]                      wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]                      rd_addr_reg, rd_addr_next;
    logic signed [SAMPLE_BITS-1:0]      samp_q_reg;
    logic signed [ofw_pkg::VALUE_W-1:0] coef_q_reg;
    meta_t                              meta1_reg;
    logic                               v1_reg;
    ofw_pkg::out_t                      res2_reg;
    logic                               v2_reg;
    logic [QAW-1:0]                     q_wr_reg, q_rd_reg;
    logic [QCW-1:0]                     q_cnt_reg, q_cnt_next;

    logic signed [SAMPLE_BITS-1:0]      samp_in;
    logic [AW+1:0]                      base_sum;
    logic [AW+1:0]                      base_wrap;
    logic [AW-1:0]                      base;
    logic signed [MUL_W-1:0]            mul_full;
    logic                               win_ok;
    logic                               pop;
    logic [OCC_W-1:0]                   occ;

    assign samp_in = SAMPLE_BITS'($unsigned(item.value));
    assign win_ok  = ({1'b0, item.coeff_index} < ofw_pkg::BLK_W'(WIN_DEPTH));

    // First ring entry of the frame closed by the sample being written
    assign base_sum  = (AW+2)'(wr_ptr_reg) + (AW+2)'(BLOCK_MAX) + (AW+2)'(1)
                       - (AW+2)'(cmd.blk);
    assign base_wrap = (base_sum >= (AW+2)'(BLOCK_MAX)) ? (base_sum - (AW+2)'(BLOCK_MAX))
                                                         : base_sum;
    assign base      = base_wrap[AW-1:0];

    assign wr_ptr_next = (wr_ptr_reg == AW'(BLOCK_MAX - 1)) ? '0
                                                            : wr_ptr_reg + AW'(1);

    always_comb
    begin
        rd_addr_next = rd_addr_reg;
        if (cmd.frame_start)
        begin
            rd_addr_next = base;
        end
        else if (cmd.issue)
        begin
            rd_addr_next = (rd_addr_reg == AW'(BLOCK_MAX - 1)) ? '0
                                                               : rd_addr_reg + AW'(1);
        end
    end

    assign mul_full = samp_q_reg * coef_q_reg;

    // Credit: elements in flight plus queued never exceed the queue depth
    assign occ        = OCC_W'(q_cnt_reg) + OCC_W'(v1_reg) + OCC_W'(v2_reg);
    assign stat.space = occ < OCC_W'(ofw_pkg::OUT_DEPTH);

    assign result_valid = (q_cnt_reg != '0);
    assign result       = q_mem[q_rd_reg];
    assign pop          = result_valid && !result_stall;

    always_comb
    begin
        q_cnt_next = q_cnt_reg;
        unique case ({v2_reg, pop})
            2'b10:   q_cnt_next = q_cnt_reg + QCW'(1);
            2'b01:   q_cnt_next = q_cnt_reg - QCW'(1);
            default: q_cnt_next = q_cnt_reg;
        endcase
    end

    // Memories and payload stages
    always_ff @(posedge clk)
    begin
        if (cmd.ring_wr)
        begin
            ring_mem[wr_ptr_reg] <= samp_in;
        end
        if (cmd.win_wr && win_ok)
        begin
            win_mem[item.coeff_index[WIN_AW-1:0]] <= item.value;
        end
        samp_q_reg <= ring_mem[rd_addr_reg];
        coef_q_reg <= win_mem[cmd.pos[WIN_AW-1:0]];
        meta1_reg.frame_index <= cmd.frame_index;
        meta1_reg.position    <= cmd.pos;
        meta1_reg.last        <= cmd.last;
        res2_reg.frame_index  <= meta1_reg.frame_index;
        res2_reg.position     <= meta1_reg.position;
        res2_reg.last         <= meta1_reg.last;
        res2_reg.product      <= ofw_pkg::PROD_W'(mul_full);
        if (v2_reg)
        begin
            q_mem[q_wr_reg] <= res2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_addr_reg <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            q_wr_reg    <= '0;
            q_rd_reg    <= '0;
            q_cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.ring_wr)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            rd_addr_reg <= rd_addr_next;
            v1_reg      <= cmd.issue;
            v2_reg      <= v1_reg;
            q_cnt_reg   <= q_cnt_next;
            if (v2_reg)
            begin
                q_wr_reg <= q_wr_reg + QAW'(1);
            end
            if (pop)
            begin
                q_rd_reg <= q_rd_reg + QAW'(1);
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        occ <= OCC_W'(ofw_pkg::OUT_DEPTH))
        else $error("result queue overrun");

    a_rd_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_addr_reg < AW'(BLOCK_MAX - 1) || rd_addr_reg == AW'(BLOCK_MAX - 1))
        else $error("ring read address out of range");

    a_issue_with_credit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> stat.space)
        else $error("element issued without queue credit");
`endif

endmodule

`default_nettype wire
